[hw/rtl/jafe_pkg.sv]
// ----------------------------------------------------------------------------
// jafe_pkg
// shared types and constants of the json array frame extractor
// ----------------------------------------------------------------------------
package jafe_pkg;

  // buffer length and bracket nesting limit
  localparam int MAX_LEN   = 256;
  localparam int MAX_DEPTH = 255;

  // last buffer index, never stored: stores stop below it
  localparam logic [7:0] LAST_POS  = 8'(MAX_LEN - 1);
  localparam logic [7:0] DEPTH_MAX = 8'(MAX_DEPTH);

  // input operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_OPEN   = 8'h5B;
  localparam logic [7:0] CH_CLOSE  = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ESCAPE = 8'h5C;

  // configuration register indexes
  localparam logic REG_FRAME_TIMEOUT    = 1'b0;
  localparam logic REG_ACTIVITY_TIMEOUT = 1'b1;

  localparam logic [15:0] FRAME_TIMEOUT_RST    = 16'd1000;
  localparam logic [15:0] ACTIVITY_TIMEOUT_RST = 16'd5000;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } jafe_in_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_byte;
    logic [7:0] store_index;
    logic       frame_end;
    logic       frame_good;
    logic [7:0] frame_length;
    logic       frame_dropped;
    logic       connected;
  } jafe_out_t;

  typedef struct packed {
    logic [7:0]  nesting_depth;
    logic [7:0]  write_position;
    logic        overflowed;
    logic        inside_string;
    logic        escape_pending;
    logic [15:0] idle_ticks;
    logic        byte_seen;
  } jafe_state_t;

  typedef struct packed {
    logic [15:0] frame_timeout;
    logic [15:0] activity_timeout;
  } jafe_cfg_t;

endpackage

[hw/rtl/json_array_frame_extractor_top.sv]
// ----------------------------------------------------------------------------
// json_array_frame_extractor_top
// frames json arrays out of a received byte stream with stall timeout
// ----------------------------------------------------------------------------
// usage
//   in channel: one request per received byte (operation 0) or per one
//   millisecond tick (operation 1), valid/ready handshake
//   out channel: exactly one result per input request, carrying the memory
//   write for a stored byte, frame end with good flag and length, a dropped
//   frame flag and the link connected status
//   cfg port: apb style, register 0 frame timeout at byte address 0,
//   register 1 activity timeout at byte address 4, both 16 bit
// timing
//   the result is valid in the cycle after the input is accepted
//   one request per cycle sustained while out_ready is high: the framing
//   update is a single pass of compare and increment logic between the
//   state register and the result register
// reset
//   framing state, idle count and link status clear, timeouts return to
//   1000 and 5000 ticks, no result pending
// stalls
//   the result register holds while out_ready is low; in_ready follows so
//   one finished result may wait while nothing new is taken
// ----------------------------------------------------------------------------
module json_array_frame_extractor_top (
  input  logic                clk,
  input  logic                rst_n,
  // input requests
  input  logic                in_valid,
  output logic                in_ready,
  input  jafe_pkg::jafe_in_t  in_data,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output jafe_pkg::jafe_out_t out_data,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  jafe_pkg::jafe_state_t state_r, state_nxt;
  jafe_pkg::jafe_out_t   out_data_r, res_nxt;
  jafe_pkg::jafe_cfg_t   cfg_r;
  logic                  out_valid_r;
  logic                  in_fire;
  logic                  cfg_wr;

  // --- configuration port ---------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // word select on address bit 2, byte offset ignored
  always_comb begin
    unique case (cfg_paddr[2])
      jafe_pkg::REG_FRAME_TIMEOUT: cfg_prdata = {16'd0, cfg_r.frame_timeout};
      default:                     cfg_prdata = {16'd0, cfg_r.activity_timeout};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_timeout    <= jafe_pkg::FRAME_TIMEOUT_RST;
      cfg_r.activity_timeout <= jafe_pkg::ACTIVITY_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == jafe_pkg::REG_FRAME_TIMEOUT) begin
        cfg_r.frame_timeout <= cfg_pwdata[15:0];
      end else begin
        cfg_r.activity_timeout <= cfg_pwdata[15:0];
      end
    end
  end

  // --- framing update -------------------------------------------------------
  jafe_step u_step (
    .cur  (state_r),
    .item (in_data),
    .cfg  (cfg_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // accept while the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // an accepted request always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // stored index never reaches the last buffer slot
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.store_valid) |-> (out_data_r.store_index < jafe_pkg::LAST_POS))
    else $error("store index beyond buffer");

  // a dropped frame comes only from a tick, never with a store or frame end
  a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_dropped) |->
      (!out_data_r.store_valid && !out_data_r.frame_end))
    else $error("frame drop mixed with byte result");

  // framing flags only live inside an open frame
  a_flags_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.overflowed || state_r.inside_string) |-> (state_r.nesting_depth != 8'd0))
    else $error("framing flag set outside a frame");

  // escape only pending inside a string
  a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.escape_pending |-> state_r.inside_string)
    else $error("escape pending outside a string");
`endif

endmodule

[hw/rtl/jafe_step.sv]
// ----------------------------------------------------------------------------
// jafe_step
// next framing state and result for one byte or tick
// ----------------------------------------------------------------------------
module jafe_step (
  input  jafe_pkg::jafe_state_t cur,
  input  jafe_pkg::jafe_in_t    item,
  input  jafe_pkg::jafe_cfg_t   cfg,
  output jafe_pkg::jafe_state_t nxt,
  output jafe_pkg::jafe_out_t   res
);

  logic [16:0] elapsed;
  logic [7:0]  depth_dec;

  assign elapsed   = {1'b0, cur.idle_ticks} + 17'd1;
  assign depth_dec = cur.nesting_depth - 8'd1;

  always_comb begin
    nxt = cur;
    res = '0;
    if (item.operation == jafe_pkg::OP_TICK) begin
      if ((cur.nesting_depth != 8'd0) && cur.byte_seen &&
          (elapsed > {1'b0, cfg.frame_timeout})) begin
        nxt.nesting_depth  = 8'd0;
        nxt.write_position = 8'd0;
        nxt.overflowed     = 1'b0;
        nxt.inside_string  = 1'b0;
        nxt.escape_pending = 1'b0;
        res.frame_dropped  = 1'b1;
      end
      nxt.idle_ticks = elapsed[16] ? 16'hFFFF : elapsed[15:0];
    end else begin
      nxt.idle_ticks = 16'd0;
      nxt.byte_seen  = 1'b1;
      if (cur.nesting_depth == 8'd0) begin
        // hunt for frame start
        if (item.data_byte == jafe_pkg::CH_OPEN) begin
          nxt.nesting_depth  = 8'd1;
          nxt.write_position = 8'd1;
          nxt.overflowed     = 1'b0;
          nxt.inside_string  = 1'b0;
          nxt.escape_pending = 1'b0;
          res.store_valid    = 1'b1;
          res.store_byte     = item.data_byte;
          res.store_index    = 8'd0;
        end
      end else begin
        if (!cur.overflowed && (cur.write_position < jafe_pkg::LAST_POS)) begin
          res.store_valid    = 1'b1;
          res.store_byte     = item.data_byte;
          res.store_index    = cur.write_position;
          nxt.write_position = cur.write_position + 8'd1;
        end else begin
          nxt.overflowed = 1'b1;
        end

        if (cur.inside_string) begin
          if (cur.escape_pending) begin
            nxt.escape_pending = 1'b0;
          end else if (item.data_byte == jafe_pkg::CH_ESCAPE) begin
            nxt.escape_pending = 1'b1;
          end else if (item.data_byte == jafe_pkg::CH_QUOTE) begin
            nxt.inside_string = 1'b0;
          end
        end else if (item.data_byte == jafe_pkg::CH_QUOTE) begin
          nxt.inside_string = 1'b1;
        end else if (item.data_byte == jafe_pkg::CH_OPEN) begin
          if (cur.nesting_depth >= jafe_pkg::DEPTH_MAX) begin
            nxt.overflowed = 1'b1;
          end else begin
            nxt.nesting_depth = cur.nesting_depth + 8'd1;
          end
        end else if (item.data_byte == jafe_pkg::CH_CLOSE) begin
          nxt.nesting_depth = depth_dec;
          if (depth_dec == 8'd0) begin
            res.frame_end      = 1'b1;
            res.frame_good     = !nxt.overflowed;
            res.frame_length   = nxt.write_position;
            nxt.write_position = 8'd0;
            nxt.overflowed     = 1'b0;
            nxt.inside_string  = 1'b0;
            nxt.escape_pending = 1'b0;
          end
        end
      end
    end
    res.connected = nxt.byte_seen && (nxt.idle_ticks < cfg.activity_timeout);
  end

endmodule
